// ===== design/wrgl_pkg.sv =====
// Shared types and constants for the windowed RGB565 gray loader.
// No dependencies; used by wrgl_pos_counter and windowed_rgb565_gray_loader.
`default_nettype none

package wrgl_pkg;

    // Widths of configuration registers and payload fields
    localparam int COORD_W   = 11;
    localparam int DIM_W     = 12;
    localparam int MODE_W    = 2;
    localparam int PIXEL_W   = 16;
    localparam int OFFSET_W  = 22;
    localparam int GRAY_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam int MAX_DIM_DEFAULT = 2048;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_FILL   = 3'd7;

    // Source modes
    localparam logic [MODE_W-1:0] MODE_RGB565      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RGB565_SWAP = 2'd1;

    // Register reset values
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd800;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd600;

    localparam logic [GRAY_W-1:0] BORDER_BYTE = 8'hF0;

    // Luma weights (percent) and the reciprocal for the divide by 100.
    // floor(x * 5243 / 2^19) == floor(x / 100) for all sums below 25037.
    localparam int SUM_W = 15;
    localparam logic [4:0]  LUMA_R = 5'd30;
    localparam logic [5:0]  LUMA_G = 6'd59;
    localparam logic [3:0]  LUMA_B = 4'd11;
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
    } t_geom;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                in_win;
        logic                last;
    } t_pos;

endpackage

`default_nettype wire

// ===== design/wrgl_pos_counter.sv =====
// Raster position tracker: column/row counters, row base offset, window test.
// Depends on wrgl_pkg.
`default_nettype none

module wrgl_pos_counter #(
    parameter int MAX_DIM = wrgl_pkg::MAX_DIM_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_advance,
    input  wrgl_pkg::t_geom     i_geom,
    output wrgl_pkg::t_pos      o_pos
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int FW_W  = CW + 1;
    localparam int CMP_W = ((CW > wrgl_pkg::DIM_W) ? CW : wrgl_pkg::DIM_W) + 1;
    localparam int EXT_W = wrgl_pkg::DIM_W + 1;

    logic [CW-1:0]                 r_col, n_col;
    logic [CW-1:0]                 r_row, n_row;
    logic [wrgl_pkg::OFFSET_W-1:0] r_base, n_base;

    logic [FW_W-1:0]  fw, fh;
    logic             col_end, row_end;
    logic [CMP_W-1:0] col_x, row_x, left_x, top_x, right_x, bottom_x;

    // Frame size 0 acts as 1, sizes above MAX_DIM saturate
    function automatic logic [FW_W-1:0] clamp_dim(input logic [wrgl_pkg::DIM_W-1:0] d);
        logic [EXT_W-1:0] ext;
        ext = {1'b0, d};
        if (d == '0) begin
            clamp_dim = FW_W'(1);
        end else if (ext > EXT_W'(MAX_DIM)) begin
            clamp_dim = FW_W'(MAX_DIM);
        end else begin
            clamp_dim = FW_W'(ext);
        end
    endfunction

    always_comb begin
        fw = clamp_dim(i_geom.frame_width);
        fh = clamp_dim(i_geom.frame_height);
        col_end = (FW_W'(r_col) + FW_W'(1)) >= fw;
        row_end = (FW_W'(r_row) + FW_W'(1)) >= fh;

        col_x    = CMP_W'(r_col);
        row_x    = CMP_W'(r_row);
        left_x   = CMP_W'(i_geom.left);
        top_x    = CMP_W'(i_geom.top);
        right_x  = CMP_W'(i_geom.left) + CMP_W'(i_geom.width);
        bottom_x = CMP_W'(i_geom.top) + CMP_W'(i_geom.height);

        o_pos.in_win = (col_x >= left_x) && (col_x < right_x) &&
                       (row_x >= top_x) && (row_x < bottom_x);
        o_pos.last   = col_end && row_end;
        o_pos.offset = r_base + wrgl_pkg::OFFSET_W'(r_col);

        n_col  = r_col;
        n_row  = r_row;
        n_base = r_base;
        if (col_end) begin
            n_col = '0;
            if (row_end) begin
                n_row  = '0;
                n_base = '0;
            end else begin
                n_row  = r_row + CW'(1);
                n_base = r_base + wrgl_pkg::OFFSET_W'(fw);
            end
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end else if (i_advance) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_base <= n_base;
        end
    end

endmodule

`default_nettype wire

// ===== design/windowed_rgb565_gray_loader.sv =====
// Windowed RGB565 gray loader, top level: config registers, luma pipeline.
// Depends on wrgl_pkg and wrgl_pos_counter.
// Requests pass stage 1 and stage 2 registers; one per cycle unless i_stall holds them.
// Stage 1 registers position, flags and the weighted luma sum; stage 2 divides by 100.
// Reset (i_rst_n, synchronous): pipeline empty, counters at origin, registers at defaults.
`default_nettype none

module windowed_rgb565_gray_loader #(
    parameter int MAX_DIM = wrgl_pkg::MAX_DIM_DEFAULT
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // config write port
    input  wire                               i_cfg_we,
    input  wire  [wrgl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [wrgl_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // request channel
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire  [wrgl_pkg::PIXEL_W-1:0]      i_source_pixel,
    // result channel
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic [wrgl_pkg::OFFSET_W-1:0]     o_write_offset,
    output logic [wrgl_pkg::GRAY_W-1:0]       o_gray_byte,
    output logic                              o_write_enable,
    output logic                              o_pixel_used,
    output logic                              o_frame_last
);

    // What stage 2 turns into the output byte
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_BORDER = 2'd1;
    localparam logic [1:0] KIND_RAW    = 2'd2;
    localparam logic [1:0] KIND_LUMA   = 2'd3;

    localparam int PROD_W = wrgl_pkg::SUM_W + wrgl_pkg::RECIP_W;

    // ---------------- configuration registers ----------------
    wrgl_pkg::t_geom                 r_geom;
    logic [wrgl_pkg::MODE_W-1:0]     r_mode;
    logic                            r_border;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.left         <= '0;
            r_geom.top          <= '0;
            r_geom.width        <= '0;
            r_geom.height       <= '0;
            r_geom.frame_width  <= wrgl_pkg::FRAME_WIDTH_RST;
            r_geom.frame_height <= wrgl_pkg::FRAME_HEIGHT_RST;
            r_mode              <= wrgl_pkg::MODE_RGB565;
            r_border            <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wrgl_pkg::REG_WINDOW_LEFT:   r_geom.left   <= i_cfg_data[wrgl_pkg::COORD_W-1:0];
                wrgl_pkg::REG_WINDOW_TOP:    r_geom.top    <= i_cfg_data[wrgl_pkg::COORD_W-1:0];
                wrgl_pkg::REG_WINDOW_WIDTH:  r_geom.width  <= i_cfg_data;
                wrgl_pkg::REG_WINDOW_HEIGHT: r_geom.height <= i_cfg_data;
                wrgl_pkg::REG_FRAME_WIDTH:   r_geom.frame_width  <= i_cfg_data;
                wrgl_pkg::REG_FRAME_HEIGHT:  r_geom.frame_height <= i_cfg_data;
                wrgl_pkg::REG_SOURCE_MODE:   r_mode   <= i_cfg_data[wrgl_pkg::MODE_W-1:0];
                wrgl_pkg::REG_BORDER_FILL:   r_border <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // Both stages move together unless the output is stalled; a bubble in
    // either stage is filled even while the result side holds back.
    logic r1_valid, r2_valid;
    logic s1_load, s2_load, accept;

    assign s2_load = !r2_valid || !i_stall;
    assign s1_load = !r1_valid || s2_load;
    assign o_stall = !s1_load;
    assign accept  = i_valid && s1_load;

    // ---------------- position tracking ----------------
    wrgl_pkg::t_pos pos;

    wrgl_pos_counter #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_geom    (r_geom),
        .o_pos     (pos)
    );

    // ---------------- stage 1: luma sum ----------------
    logic [wrgl_pkg::PIXEL_W-1:0] pix;
    logic [7:0]                   r8, g8, b8;
    logic [wrgl_pkg::SUM_W-1:0]   luma_sum;
    logic [wrgl_pkg::SUM_W-1:0]   n1_sum;
    logic [1:0]                   n1_kind;
    logic                         is_565;

    always_comb begin
        pix    = (r_mode == wrgl_pkg::MODE_RGB565_SWAP) ?
                 {i_source_pixel[7:0], i_source_pixel[15:8]} : i_source_pixel;
        is_565 = r_mode inside {wrgl_pkg::MODE_RGB565, wrgl_pkg::MODE_RGB565_SWAP};
        r8 = {pix[15:11], 3'b000};
        g8 = {pix[10:5], 2'b00};
        b8 = {pix[4:0], 3'b000};
        luma_sum = wrgl_pkg::SUM_W'(r8) * wrgl_pkg::SUM_W'(wrgl_pkg::LUMA_R)
                 + wrgl_pkg::SUM_W'(g8) * wrgl_pkg::SUM_W'(wrgl_pkg::LUMA_G)
                 + wrgl_pkg::SUM_W'(b8) * wrgl_pkg::SUM_W'(wrgl_pkg::LUMA_B);

        // gray8 mode (and unused mode 3) passes the low byte through
        n1_sum  = is_565 ? luma_sum : wrgl_pkg::SUM_W'(i_source_pixel[7:0]);
        if (pos.in_win) begin
            n1_kind = is_565 ? KIND_LUMA : KIND_RAW;
        end else if (r_border) begin
            n1_kind = KIND_BORDER;
        end else begin
            n1_kind = KIND_NONE;
        end
    end

    logic [wrgl_pkg::OFFSET_W-1:0] r1_offset;
    logic [wrgl_pkg::SUM_W-1:0]    r1_sum;
    logic [1:0]                    r1_kind;
    logic                          r1_used, r1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_load) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_offset <= pos.offset;
            r1_sum    <= n1_sum;
            r1_kind   <= n1_kind;
            r1_used   <= pos.in_win;
            r1_last   <= pos.last;
        end
    end

    // ---------------- stage 2: divide by 100, pick the byte ----------------
    logic [PROD_W-1:0]          prod;
    logic [wrgl_pkg::GRAY_W-1:0] n2_gray;

    always_comb begin
        prod = PROD_W'(r1_sum) * PROD_W'(wrgl_pkg::RECIP_100);
        case (r1_kind)
            KIND_LUMA:   n2_gray = prod[wrgl_pkg::RECIP_SHIFT +: wrgl_pkg::GRAY_W];
            KIND_RAW:    n2_gray = r1_sum[wrgl_pkg::GRAY_W-1:0];
            KIND_BORDER: n2_gray = wrgl_pkg::BORDER_BYTE;
            default:     n2_gray = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_load) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r1_valid) begin
            o_write_offset <= r1_offset;
            o_gray_byte    <= n2_gray;
            o_write_enable <= (r1_kind != KIND_NONE);
            o_pixel_used   <= r1_used;
            o_frame_last   <= r1_last;
        end
    end

    assign o_valid = r2_valid;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for windowed_rgb565_gray_loader: random bursts of pixel
// requests over changing window, frame and mode settings, checked per field.
// Depends on wrgl_pkg and the loader RTL.
`default_nettype none

module tb_top;
    import wrgl_pkg::*;

    localparam int MAX_DIM = MAX_DIM_DEFAULT;

    // Source modes the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_GRAY8 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Minimum number of random pixel requests after the directed part
    localparam int RANDOM_PIXELS = 1650;

    // One frame buffer write as the block should present it
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [GRAY_W-1:0]   gray;
        logic                we;
        logic                used;
        logic                last;
    } t_fb_write;

    // Scoreboard: shadow registers, raster counters and queued writes
    class wrgl_scoreboard;
        logic [COORD_W-1:0]  win_left = '0;
        logic [COORD_W-1:0]  win_top = '0;
        logic [DIM_W-1:0]    win_width = '0;
        logic [DIM_W-1:0]    win_height = '0;
        logic [DIM_W-1:0]    fb_width = FRAME_WIDTH_RST;
        logic [DIM_W-1:0]    fb_height = FRAME_HEIGHT_RST;
        logic [MODE_W-1:0]   src_mode = MODE_RGB565;
        logic                border_on = 1'b1;
        int unsigned         col = 0;
        int unsigned         row = 0;
        logic [OFFSET_W-1:0] row_base = '0;
        t_fb_write           pending_writes[$];
        int                  errors = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_WINDOW_LEFT:   win_left = data[COORD_W-1:0];
                REG_WINDOW_TOP:    win_top = data[COORD_W-1:0];
                REG_WINDOW_WIDTH:  win_width = data;
                REG_WINDOW_HEIGHT: win_height = data;
                REG_FRAME_WIDTH:   fb_width = data;
                REG_FRAME_HEIGHT:  fb_height = data;
                REG_SOURCE_MODE:   src_mode = data[MODE_W-1:0];
                REG_BORDER_FILL:   border_on = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] d);
            if (d == 0) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return d;
        endfunction

        function logic [GRAY_W-1:0] luma_565(logic [PIXEL_W-1:0] p);
            int unsigned r8, g8, b8;
            r8 = {p[15:11], 3'b000};
            g8 = {p[10:5], 2'b00};
            b8 = {p[4:0], 3'b000};
            return GRAY_W'((r8 * LUMA_R + g8 * LUMA_G + b8 * LUMA_B) / 100);
        endfunction

        // Predict the write for one accepted pixel request and advance the raster
        function void note_request(logic [PIXEL_W-1:0] px);
            int unsigned fw, fh, x0, x1, y0, y1;
            bit          in_win, col_end, row_end;
            t_fb_write   w;
            fw = clamp_dim(fb_width);
            fh = clamp_dim(fb_height);
            x0 = win_left;
            x1 = x0 + win_width;
            y0 = win_top;
            y1 = y0 + win_height;
            in_win = col >= x0 && col < x1 && row >= y0 && row < y1;
            col_end = col + 1 >= fw;
            row_end = row + 1 >= fh;
            w.offset = row_base + OFFSET_W'(col);
            w.gray = '0;
            w.we = 1'b0;
            if (in_win) begin
                w.we = 1'b1;
                case (src_mode)
                    MODE_RGB565:      w.gray = luma_565(px);
                    MODE_RGB565_SWAP: w.gray = luma_565({px[7:0], px[15:8]});
                    default:          w.gray = px[7:0];
                endcase
            end else if (border_on) begin
                w.we = 1'b1;
                w.gray = BORDER_BYTE;
            end
            w.used = in_win;
            w.last = col_end && row_end;
            pending_writes.push_back(w);

            if (col_end) begin
                col = 0;
                if (row_end) begin
                    row = 0;
                    row_base = '0;
                end else begin
                    row = row + 1;
                    row_base = row_base + OFFSET_W'(fw);
                end
            end else begin
                col = col + 1;
            end
        endfunction

        function void check_result(t_fb_write got);
            t_fb_write exp;
            if (pending_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected write: expected none", $time);
                $display("    actual   offset %0h gray %0h we %b used %b last %b",
                         got.offset, got.gray, got.we, got.used, got.last);
                return;
            end
            exp = pending_writes.pop_front();
            if (got !== exp) begin
                errors++;
                $display("%0t: write mismatch", $time);
                $display("    expected offset %0h gray %0h we %b used %b last %b",
                         exp.offset, exp.gray, exp.we, exp.used, exp.last);
                $display("    actual   offset %0h gray %0h we %b used %b last %b",
                         got.offset, got.gray, got.we, got.used, got.last);
            end
        endfunction

        function int pending_count();
            return pending_writes.size();
        endfunction
    endclass

    // Clock, reset and every input start at known values
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic [PIXEL_W-1:0]   i_source_pixel = '0;
    logic                 i_stall = 1'b0;

    wire                  o_stall;
    wire                  o_valid;
    wire [OFFSET_W-1:0]   o_write_offset;
    wire [GRAY_W-1:0]     o_gray_byte;
    wire                  o_write_enable;
    wire                  o_pixel_used;
    wire                  o_frame_last;

    wrgl_scoreboard sb;

    windowed_rgb565_gray_loader #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_source_pixel (i_source_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_offset (o_write_offset),
        .o_gray_byte    (o_gray_byte),
        .o_write_enable (o_write_enable),
        .o_pixel_used   (o_pixel_used),
        .o_frame_last   (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    // Monitor: values read here are the ones present at the edge, since all
    // bench and RTL updates land in the NBA region afterwards.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_request(i_source_pixel);
            if (o_valid && !i_stall)
                sb.check_result({o_write_offset, o_gray_byte, o_write_enable,
                                 o_pixel_used, o_frame_last});
        end
    end

    // Result-side stall pattern, switching at random between styles:
    // no stall, random stall, alternating, and occasional long stalls.
    int unsigned stall_style = 0;
    int unsigned style_left = 0;
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(20, 200);
        end else begin
            style_left = style_left - 1;
        end
        case (stall_style)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 4);
            2: i_stall <= ~i_stall;
            default: begin
                if (stall_left != 0) begin
                    stall_left = stall_left - 1;
                    i_stall <= 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(0, 11);
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        endcase
    end

    // Register write; the caller lowers i_cfg_we after its batch so that the
    // enable is never dropped and raised in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DAT_W'(data);
        @(posedge i_clk);
        sb.set_reg(idx, CFG_DAT_W'(data));
    endtask

    task automatic write_all(input int unsigned left, input int unsigned top,
                             input int unsigned ww, input int unsigned wh,
                             input int unsigned fw, input int unsigned fh,
                             input logic [MODE_W-1:0] mode, input int unsigned border);
        write_reg(REG_WINDOW_LEFT, left);
        write_reg(REG_WINDOW_TOP, top);
        write_reg(REG_WINDOW_WIDTH, ww);
        write_reg(REG_WINDOW_HEIGHT, wh);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_SOURCE_MODE, mode);
        write_reg(REG_BORDER_FILL, border);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid and let the pipeline drain before touching registers; the
    // first edge makes sure the monitor has logged the last accepted request
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Present one pixel request and hold it until accepted; valid stays high
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        i_valid <= 1'b1;
        i_source_pixel <= px;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
    endtask

    // Random pixels in bursts; some bursts follow on with no gap at all
    task automatic send_random(input int count);
        int burst;
        int gap;
        burst = $urandom_range(1, 40);
        repeat (count) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    i_source_pixel <= PIXEL_W'($urandom);
                    repeat (gap) @(posedge i_clk);
                end
            end
            case ($urandom_range(0, 9))
                0: send_pixel('0);
                1: send_pixel('1);
                default: send_pixel(PIXEL_W'($urandom));
            endcase
            burst--;
        end
    endtask

    // Frame dimension: mostly tiny so frames complete often, sometimes the
    // extremes (zero, one, clamp edge, above the clamp, all ones).
    function automatic int unsigned pick_dim();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 12);
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return MAX_DIM;
            3: return MAX_DIM + 1;
            default: return (1 << DIM_W) - 1;
        endcase
    endfunction

    // Window start near the frame, occasionally anywhere (upper data bit too)
    function automatic int unsigned pick_origin(input int unsigned dim);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, (1 << DIM_W) - 1);
        return $urandom_range(0, (dim > 16) ? 16 : dim);
    endfunction

    function automatic int unsigned pick_extent(input int unsigned dim);
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return MAX_DIM;
                2: return (1 << DIM_W) - 1;
                default: return $urandom_range(0, (1 << DIM_W) - 1);
            endcase
        end
        return $urandom_range(0, (dim > 16 ? 16 : dim) + 1);
    endfunction

    // New random settings: each register rewritten with even odds, so the
    // raster counters often carry over from a frame of another size.
    task automatic random_settings(output int frame_area);
        int unsigned fw, fh, cw, ch;
        fw = pick_dim();
        fh = pick_dim();
        if ($urandom_range(0, 1)) write_reg(REG_FRAME_WIDTH, fw);
        if ($urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, fh);
        cw = sb.clamp_dim(sb.fb_width);
        ch = sb.clamp_dim(sb.fb_height);
        if ($urandom_range(0, 1)) write_reg(REG_WINDOW_LEFT, pick_origin(cw));
        if ($urandom_range(0, 1)) write_reg(REG_WINDOW_TOP, pick_origin(ch));
        if ($urandom_range(0, 1)) write_reg(REG_WINDOW_WIDTH, pick_extent(cw));
        if ($urandom_range(0, 1)) write_reg(REG_WINDOW_HEIGHT, pick_extent(ch));
        if ($urandom_range(0, 1)) write_reg(REG_SOURCE_MODE, $urandom_range(0, 3));
        if ($urandom_range(0, 1)) write_reg(REG_BORDER_FILL, $urandom_range(0, 1));
        i_cfg_we <= 1'b0;
        frame_area = cw * ch;
    endtask

    // Stimulus
    initial begin
        logic [PIXEL_W-1:0] rgb_px[$];
        logic [PIXEL_W-1:0] swap_px[$];
        int sent;
        int area;
        int count;

        sb = new();
        rgb_px = '{16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
                   16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
        swap_px = '{16'h00F8, 16'hE007, 16'h1F00, 16'hFFFF};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty window, border fill on the large default frame
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h1234);
        wait_idle();

        // Small frame, window inside it, plain RGB565 with border fill; the
        // old column position wraps on the narrower frame
        write_all(1, 0, 2, 1, 4, 2, MODE_RGB565, 1);
        foreach (rgb_px[i])
            send_pixel(rgb_px[i]);
        wait_idle();

        // Zero frame width acts as one; oversized window gets clipped
        write_all(0, 0, (1 << DIM_W) - 1, (1 << DIM_W) - 1, 0, 2, MODE_RGB565_SWAP, 0);
        foreach (swap_px[i])
            send_pixel(swap_px[i]);
        wait_idle();

        // Gray8 and the spare mode, alternating inside and untouched outside
        write_all(0, 0, 1, 1, 2, 1, MODE_GRAY8, 0);
        send_pixel(16'h00AB);
        send_pixel(16'hFF00);
        wait_idle();
        write_reg(REG_SOURCE_MODE, MODE_SPARE);
        i_cfg_we <= 1'b0;
        send_pixel(16'h1234);
        send_pixel(16'h80FF);
        wait_idle();

        // Random phases, mostly small frames so that frame ends come often
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            random_settings(area);
            count = $urandom_range(1, (3 * area > 150) ? 150 : 3 * area);
            send_random(count);
            sent += count;
            wait_idle();
        end

        // Drained by wait_idle; give any stray write time to show up
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog: about 1.8k requests, each with at worst the longest gap and
    // stall, plus drain time per phase, stay well below the time limit set here.
    initial begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
